// ===== design/hierarchical_transform_compose_top_assert.svh =====
// Assertion macros for the transform composer top level.
`ifndef HIERARCHICAL_TRANSFORM_COMPOSE_TOP_ASSERT_SVH
`define HIERARCHICAL_TRANSFORM_COMPOSE_TOP_ASSERT_SVH
`ifndef SYNTH
`define HTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("htc assertion failed");
`define HTC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("htc assertion failed");
`else
`define HTC_ASSERT_NEXT(lbl, ante, cons)
`define HTC_ASSERT_NOW(lbl, ante, cons)
`endif
`endif

// ===== design/htc_pkg.sv =====
`timescale 1ns / 1ps
package htc_pkg;

  localparam int unsigned ENTITY_COUNT = 1024;
  localparam int unsigned ENT_W        = 10;
  localparam int unsigned ENT_AW       = $clog2(ENTITY_COUNT);
  localparam int unsigned WA_W         = ENT_AW + 4;
  localparam int unsigned WORLD_DEPTH  = ENTITY_COUNT * 16;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned RND_W     = PROD_W - FRAC_BITS;
  localparam int unsigned ACC_W     = RND_W + 2;

  localparam logic signed [DATA_W-1:0] FX_ONE  = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [PROD_W-1:0] FX_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // CORDIC in Q2.30
  localparam int unsigned CORDIC_STEPS = 15;
  localparam int unsigned CS_W         = 4;
  localparam int unsigned CX_W         = 33;
  localparam int unsigned CZ_W         = 18;
  localparam int unsigned ANG_W        = 16;
  localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);
  localparam int unsigned TRIG_SH = 30 - FRAC_BITS;
  localparam logic signed [CX_W-1:0] TRIG_HALF = CX_W'(1) << (TRIG_SH - 1);
  localparam logic [ANG_W-1:0] ANG_EIGHTH = ANG_W'(8192);

  localparam int unsigned CNT_W = 5;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_VREAD, ST_PLOAD, ST_CORDIC, ST_TRIG, ST_RXY,
    ST_RMUL, ST_SCL, ST_PAR, ST_DRAIN, ST_WB, ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {PH_RXY, PH_R, PH_SCL, PH_PAR} phase_e;

  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_e;

  typedef struct packed {
    logic              load;
    logic              clr_we;
    logic [ENT_AW-1:0] clr_addr;
    logic              v_rd;
    logic              p_rd;
    logic              cordic;
    logic              trig;
    logic              mac;
    phase_e            ph;
    logic [1:0]        mi;
    logic [1:0]        mj;
    logic [1:0]        mk;
    logic              mfirst;
    logic              mlast;
    logic              wb;
    logic              wb_first;
    logic [3:0]        idx;
    logic [1:0]        row;
  } htc_cmd_t;

  typedef struct packed {
    logic use_par;
  } htc_stat_t;

  function automatic logic signed [CZ_W-1:0] atan_lut(logic [CS_W-1:0] i);
    logic signed [CZ_W-1:0] v;
    unique case (i)
      4'd0:    v = CZ_W'(8192);
      4'd1:    v = CZ_W'(4836);
      4'd2:    v = CZ_W'(2555);
      4'd3:    v = CZ_W'(1297);
      4'd4:    v = CZ_W'(651);
      4'd5:    v = CZ_W'(326);
      4'd6:    v = CZ_W'(163);
      4'd7:    v = CZ_W'(81);
      4'd8:    v = CZ_W'(41);
      4'd9:    v = CZ_W'(20);
      4'd10:   v = CZ_W'(10);
      4'd11:   v = CZ_W'(5);
      4'd12:   v = CZ_W'(3);
      4'd13:   v = CZ_W'(1);
      4'd14:   v = CZ_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Element (r, c) of an elementary rotation, r and c below 3
  function automatic logic signed [DATA_W-1:0] rot_elem(axis_e ax, logic [1:0] r,
      logic [1:0] c, logic signed [DATA_W-1:0] cv, logic signed [DATA_W-1:0] sv);
    logic signed [DATA_W-1:0] v;
    v = '0;
    unique case (ax)
      AX_X: begin
        if (r == 2'd0 && c == 2'd0) v = FX_ONE;
        if ((r == 2'd1 && c == 2'd1) || (r == 2'd2 && c == 2'd2)) v = cv;
        if (r == 2'd1 && c == 2'd2) v = -sv;
        if (r == 2'd2 && c == 2'd1) v = sv;
      end
      AX_Y: begin
        if (r == 2'd1 && c == 2'd1) v = FX_ONE;
        if ((r == 2'd0 && c == 2'd0) || (r == 2'd2 && c == 2'd2)) v = cv;
        if (r == 2'd0 && c == 2'd2) v = sv;
        if (r == 2'd2 && c == 2'd0) v = -sv;
      end
      AX_Z: begin
        if (r == 2'd2 && c == 2'd2) v = FX_ONE;
        if ((r == 2'd0 && c == 2'd0) || (r == 2'd1 && c == 2'd1)) v = cv;
        if (r == 2'd0 && c == 2'd1) v = -sv;
        if (r == 2'd1 && c == 2'd0) v = sv;
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/htc_ram.sv =====
`timescale 1ns / 1ps
module htc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/htc_ctrl.sv =====
`timescale 1ns / 1ps
module htc_ctrl import htc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  input  htc_stat_t stat_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output htc_cmd_t  cmd_o
);

  ctrl_state_e       st_q, st_d;
  logic [ENT_AW-1:0] clr_q, clr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [1:0]        i_q, i_d, j_q, j_d, k_q, k_d;
  logic [1:0]        imax, jmax, kmax;
  logic              mac_st, mac_done, clr_done;

  assign clr_done = (clr_q == ENT_AW'(ENTITY_COUNT - 1));

  always_comb begin
    mac_st = 1'b1;
    imax   = 2'd2;
    jmax   = 2'd2;
    kmax   = 2'd2;
    unique case (st_q)
      ST_RXY, ST_RMUL: ;
      ST_SCL: kmax = 2'd0;
      ST_PAR: begin
        imax = 2'd3;
        jmax = 2'd3;
        kmax = 2'd3;
      end
      default: mac_st = 1'b0;
    endcase
    mac_done = mac_st && (i_q == imax) && (j_q == jmax) && (k_q == kmax);
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR:  if (clr_done) st_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) st_d = ST_VREAD;
      ST_VREAD:  st_d = ST_PLOAD;
      ST_PLOAD:  if (cnt_q == CNT_W'(16)) st_d = ST_CORDIC;
      ST_CORDIC: if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) st_d = ST_TRIG;
      ST_TRIG:   st_d = ST_RXY;
      ST_RXY:    if (mac_done) st_d = ST_RMUL;
      ST_RMUL:   if (mac_done) st_d = ST_SCL;
      ST_SCL:    if (mac_done) st_d = stat_i.use_par ? ST_PAR : ST_DRAIN;
      ST_PAR:    if (mac_done) st_d = ST_DRAIN;
      ST_DRAIN:  st_d = ST_WB;
      ST_WB:     if (cnt_q == CNT_W'(15)) st_d = ST_OUT;
      ST_OUT:    if (out_ready_i && cnt_q == CNT_W'(3)) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    clr_d = clr_q;
    cnt_d = cnt_q;
    i_d   = i_q;
    j_d   = j_q;
    k_d   = k_q;
    if (st_q == ST_CLEAR) clr_d = clr_q + ENT_AW'(1);
    if (st_d != st_q) begin
      cnt_d = '0;
    end else if (st_q == ST_PLOAD || st_q == ST_CORDIC || st_q == ST_WB ||
                 (st_q == ST_OUT && out_ready_i)) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (mac_st) begin
      if (k_q != kmax) begin
        k_d = k_q + 2'd1;
      end else begin
        k_d = '0;
        if (j_q != jmax) begin
          j_d = j_q + 2'd1;
        end else begin
          j_d = '0;
          i_d = (i_q != imax) ? i_q + 2'd1 : 2'd0;
        end
      end
    end
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (st_q == ST_IDLE) && in_valid_i;
    cmd_o.clr_we   = (st_q == ST_CLEAR);
    cmd_o.clr_addr = clr_q;
    cmd_o.v_rd     = (st_q == ST_VREAD);
    cmd_o.p_rd     = (st_q == ST_PLOAD) && !cnt_q[CNT_W-1];
    cmd_o.cordic   = (st_q == ST_CORDIC);
    cmd_o.trig     = (st_q == ST_TRIG);
    cmd_o.mac      = mac_st;
    cmd_o.ph       = PH_RXY;
    unique case (st_q)
      ST_RMUL: cmd_o.ph = PH_R;
      ST_SCL:  cmd_o.ph = PH_SCL;
      ST_PAR:  cmd_o.ph = PH_PAR;
      default: cmd_o.ph = PH_RXY;
    endcase
    cmd_o.mi       = i_q;
    cmd_o.mj       = j_q;
    cmd_o.mk       = k_q;
    cmd_o.mfirst   = (k_q == 2'd0);
    cmd_o.mlast    = (k_q == kmax);
    cmd_o.wb       = (st_q == ST_WB);
    cmd_o.wb_first = (cnt_q == '0);
    cmd_o.idx      = cnt_q[3:0];
    cmd_o.row      = cnt_q[1:0];
    in_ready_o     = (st_q == ST_IDLE);
    out_valid_o    = (st_q == ST_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_CLEAR;
      clr_q <= '0;
      cnt_q <= '0;
      i_q   <= '0;
      j_q   <= '0;
      k_q   <= '0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      i_q   <= i_d;
      j_q   <= j_d;
      k_q   <= k_d;
    end
  end

endmodule

// ===== design/htc_dp.sv =====
`timescale 1ns / 1ps
module htc_dp import htc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  htc_cmd_t                 cmd_i,
  input  logic [ENT_W-1:0]         entity_i,
  input  logic                     has_parent_i,
  input  logic [ENT_W-1:0]         parent_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  input  logic [ANG_W-1:0]         angle_x_i,
  input  logic [ANG_W-1:0]         angle_y_i,
  input  logic [ANG_W-1:0]         angle_z_i,
  input  logic signed [DATA_W-1:0] scale_x_i,
  input  logic signed [DATA_W-1:0] scale_y_i,
  input  logic signed [DATA_W-1:0] scale_z_i,
  output htc_stat_t                stat_o,
  output logic [ENT_W-1:0]         out_entity_o,
  output logic [1:0]               row_index_o,
  output logic signed [DATA_W-1:0] col0_o,
  output logic signed [DATA_W-1:0] col1_o,
  output logic signed [DATA_W-1:0] col2_o,
  output logic signed [DATA_W-1:0] col3_o,
  output logic                     last_row_o
);

  logic [ENT_W-1:0]         entity_q, parent_q;
  logic                     has_par_q, ent_ok, par_ok;
  logic signed [DATA_W-1:0] scl_q [3];
  logic signed [CX_W-1:0]   x_q [3], y_q [3];
  logic signed [CZ_W-1:0]   z_q [3];
  logic [1:0]               quad_q [3];
  logic signed [DATA_W-1:0] cos_q [3], sin_q [3];
  logic signed [DATA_W-1:0] wm_q [16], lm_q [16], par_q [16], src [16];

  logic [ANG_W-1:0]         ang [3];
  logic [ANG_W-1:0]         ang_sum [3], ang_res [3];
  logic signed [CX_W-1:0]   x_d [3], y_d [3];
  logic signed [CZ_W-1:0]   z_d [3];
  logic signed [DATA_W-1:0] c_rnd [3], s_rnd [3], cos_d [3], sin_d [3];
  logic signed [CX_W-1:0]   xr, yr, xs, ys;

  logic                     vcap_q, pcap_q, use_par_q;
  logic [3:0]               pidx_q;

  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod_q, rsum;
  logic                     pv_q, pwm_q, pfirst_q, plast_q;
  logic [3:0]               pdst_q;
  logic signed [RND_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [ACC_W-DATA_W:0]    acc_hi;
  logic signed [DATA_W-1:0] sat_v;

  logic              v_we, v_wdata, v_rdata;
  logic [ENT_AW-1:0] v_waddr;
  logic [WA_W-1:0]   w_waddr, w_raddr;
  logic [DATA_W-1:0] w_rdata;

  assign ent_ok = (32'(entity_q) < 32'(ENTITY_COUNT));
  assign par_ok = (32'(parent_q) < 32'(ENTITY_COUNT));

  assign ang[0] = angle_x_i;
  assign ang[1] = angle_y_i;
  assign ang[2] = angle_z_i;

  // quadrant split and one CORDIC step per lane
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ang_sum[l] = ang[l] + ANG_EIGHTH;
      ang_res[l] = ang[l] - {ang_sum[l][ANG_W-1:ANG_W-2], {(ANG_W-2){1'b0}}};
      if (!z_q[l][CZ_W-1]) begin
        x_d[l] = x_q[l] - (y_q[l] >>> cmd_i.idx);
        y_d[l] = y_q[l] + (x_q[l] >>> cmd_i.idx);
        z_d[l] = z_q[l] - atan_lut(cmd_i.idx);
      end else begin
        x_d[l] = x_q[l] + (y_q[l] >>> cmd_i.idx);
        y_d[l] = y_q[l] - (x_q[l] >>> cmd_i.idx);
        z_d[l] = z_q[l] + atan_lut(cmd_i.idx);
      end
    end
  end

  // round to the working format and rotate by the quadrant
  always_comb begin
    xr = '0;
    yr = '0;
    xs = '0;
    ys = '0;
    for (int l = 0; l < 3; l++) begin
      xr = x_q[l] + TRIG_HALF;
      yr = y_q[l] + TRIG_HALF;
      xs = xr >>> TRIG_SH;
      ys = yr >>> TRIG_SH;
      c_rnd[l] = DATA_W'(xs);
      s_rnd[l] = DATA_W'(ys);
      unique case (quad_q[l])
        2'd0: begin cos_d[l] = c_rnd[l];  sin_d[l] = s_rnd[l];  end
        2'd1: begin cos_d[l] = -s_rnd[l]; sin_d[l] = c_rnd[l];  end
        2'd2: begin cos_d[l] = -c_rnd[l]; sin_d[l] = -s_rnd[l]; end
        default: begin cos_d[l] = s_rnd[l]; sin_d[l] = -c_rnd[l]; end
      endcase
    end
  end

  // multiplier operand selection
  always_comb begin
    unique case (cmd_i.ph)
      PH_RXY: begin
        op_a = rot_elem(AX_X, cmd_i.mi, cmd_i.mk, cos_q[0], sin_q[0]);
        op_b = rot_elem(AX_Y, cmd_i.mk, cmd_i.mj, cos_q[1], sin_q[1]);
      end
      PH_R: begin
        op_a = wm_q[{cmd_i.mi, cmd_i.mk}];
        op_b = rot_elem(AX_Z, cmd_i.mk, cmd_i.mj, cos_q[2], sin_q[2]);
      end
      PH_SCL: begin
        op_a = lm_q[{cmd_i.mi, cmd_i.mj}];
        op_b = scl_q[cmd_i.mj];
      end
      default: begin
        op_a = par_q[{cmd_i.mi, cmd_i.mk}];
        op_b = lm_q[{cmd_i.mk, cmd_i.mj}];
      end
    endcase
  end

  // round each product half up, sum exactly, saturate the element
  always_comb begin
    rsum   = prod_q + FX_HALF;
    rnd    = rsum[PROD_W-1:FRAC_BITS];
    acc_d  = (pfirst_q ? ACC_W'(0) : acc_q) + ACC_W'(rnd);
    acc_hi = acc_d[ACC_W-1:DATA_W-1];
    if (acc_hi == '0 || acc_hi == '1) begin
      sat_v = acc_d[DATA_W-1:0];
    end else if (acc_d[ACC_W-1]) begin
      sat_v = SAT_MIN;
    end else begin
      sat_v = SAT_MAX;
    end
  end

  always_comb begin
    for (int e = 0; e < 16; e++) begin
      src[e] = use_par_q ? wm_q[e] : lm_q[e];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcap_q    <= 1'b0;
      pcap_q    <= 1'b0;
      use_par_q <= 1'b0;
      pv_q      <= 1'b0;
    end else begin
      vcap_q <= cmd_i.v_rd;
      pcap_q <= cmd_i.p_rd;
      pv_q   <= cmd_i.mac;
      if (vcap_q) use_par_q <= has_par_q && par_ok && v_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= cmd_i.idx;
    if (cmd_i.load) begin
      entity_q  <= entity_i;
      parent_q  <= parent_i;
      has_par_q <= has_parent_i;
      scl_q[0]  <= scale_x_i;
      scl_q[1]  <= scale_y_i;
      scl_q[2]  <= scale_z_i;
      lm_q[3]   <= pos_x_i;
      lm_q[7]   <= pos_y_i;
      lm_q[11]  <= pos_z_i;
      lm_q[12]  <= '0;
      lm_q[13]  <= '0;
      lm_q[14]  <= '0;
      lm_q[15]  <= FX_ONE;
      for (int l = 0; l < 3; l++) begin
        quad_q[l] <= ang_sum[l][ANG_W-1:ANG_W-2];
        x_q[l]    <= CORDIC_GAIN;
        y_q[l]    <= '0;
        z_q[l]    <= CZ_W'($signed(ang_res[l]));
      end
    end
    if (cmd_i.cordic) begin
      for (int l = 0; l < 3; l++) begin
        x_q[l] <= x_d[l];
        y_q[l] <= y_d[l];
        z_q[l] <= z_d[l];
      end
    end
    if (cmd_i.trig) begin
      for (int l = 0; l < 3; l++) begin
        cos_q[l] <= cos_d[l];
        sin_q[l] <= sin_d[l];
      end
    end
    if (pcap_q) par_q[pidx_q] <= w_rdata;
    // multiply stage
    prod_q   <= PROD_W'(op_a) * PROD_W'(op_b);
    pdst_q   <= {cmd_i.mi, cmd_i.mj};
    pwm_q    <= (cmd_i.ph == PH_RXY) || (cmd_i.ph == PH_PAR);
    pfirst_q <= cmd_i.mfirst;
    plast_q  <= cmd_i.mlast;
    // accumulate stage
    if (pv_q) begin
      acc_q <= acc_d;
      if (plast_q) begin
        if (pwm_q) wm_q[pdst_q] <= sat_v;
        else       lm_q[pdst_q] <= sat_v;
      end
    end
  end

  // world store and valid flags
  assign w_raddr = {ENT_AW'(parent_q), cmd_i.idx};
  assign w_waddr = {ENT_AW'(entity_q), cmd_i.idx};
  assign v_we    = cmd_i.clr_we || (cmd_i.wb && cmd_i.wb_first && ent_ok);
  assign v_waddr = cmd_i.clr_we ? cmd_i.clr_addr : ENT_AW'(entity_q);
  assign v_wdata = !cmd_i.clr_we;

  htc_ram #(.WIDTH(DATA_W), .DEPTH(WORLD_DEPTH)) u_world (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wb && ent_ok),
    .waddr_i (w_waddr),
    .wdata_i (src[cmd_i.idx]),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  htc_ram #(.WIDTH(1), .DEPTH(ENTITY_COUNT)) u_valid (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .raddr_i (ENT_AW'(parent_q)),
    .rdata_o (v_rdata)
  );

  assign stat_o.use_par = use_par_q;
  assign out_entity_o   = entity_q;
  assign row_index_o    = cmd_i.row;
  assign col0_o         = src[{cmd_i.row, 2'd0}];
  assign col1_o         = src[{cmd_i.row, 2'd1}];
  assign col2_o         = src[{cmd_i.row, 2'd2}];
  assign col3_o         = src[{cmd_i.row, 2'd3}];
  assign last_row_o     = (cmd_i.row == 2'd3);

endmodule

// ===== design/hierarchical_transform_compose_top.sv =====
`timescale 1ns / 1ps
// Steps: parent fetch, 15 CORDIC steps, one rounding step, then one shared 32x32
// multiplier for 63 products (127 with a stored parent) plus a drain state, and write-back.
// A new item is accepted only after the last row of the previous one is transferred.
// Reset: asynchronous, active low; then a sweep over all 1024 entries clears the valid
// flags with in_ready_o held low.
`include "hierarchical_transform_compose_top_assert.svh"
module hierarchical_transform_compose_top import htc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [ENT_W-1:0]         entity_i,
  input  logic                     has_parent_i,
  input  logic [ENT_W-1:0]         parent_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  input  logic [ANG_W-1:0]         angle_x_i,
  input  logic [ANG_W-1:0]         angle_y_i,
  input  logic [ANG_W-1:0]         angle_z_i,
  input  logic signed [DATA_W-1:0] scale_x_i,
  input  logic signed [DATA_W-1:0] scale_y_i,
  input  logic signed [DATA_W-1:0] scale_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ENT_W-1:0]         out_entity_o,
  output logic [1:0]               row_index_o,
  output logic signed [DATA_W-1:0] col0_o,
  output logic signed [DATA_W-1:0] col1_o,
  output logic signed [DATA_W-1:0] col2_o,
  output logic signed [DATA_W-1:0] col3_o,
  output logic                     last_row_o
);

  htc_cmd_t  cmd;
  htc_stat_t stat;

  // Controller sequences the fetch, CORDIC, multiply phases, write-back and rows.
  htc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Datapath holds the matrices, the CORDIC lanes, the multiplier and both stores.
  htc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .entity_i     (entity_i),
    .has_parent_i (has_parent_i),
    .parent_i     (parent_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .angle_x_i    (angle_x_i),
    .angle_y_i    (angle_y_i),
    .angle_z_i    (angle_z_i),
    .scale_x_i    (scale_x_i),
    .scale_y_i    (scale_y_i),
    .scale_z_i    (scale_z_i),
    .stat_o       (stat),
    .out_entity_o (out_entity_o),
    .row_index_o  (row_index_o),
    .col0_o       (col0_o),
    .col1_o       (col1_o),
    .col2_o       (col2_o),
    .col3_o       (col3_o),
    .last_row_o   (last_row_o)
  );

  // Hold off new items while rows are offered; return to idle after the last transfer.
  `HTC_ASSERT_NOW(a_no_accept_during_out, out_valid_o, !in_ready_o)
  `HTC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o && !out_valid_o)
  `HTC_ASSERT_NEXT(a_idle_after_last, out_valid_o && out_ready_i && last_row_o, in_ready_o)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import htc_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned HOLD_CYCLES  = 3000;
  localparam int unsigned TAIL_CYCLES  = 250;

  // One transform request as presented on the input channel
  typedef struct {
    logic [ENT_W-1:0]         entity;
    logic                     has_parent;
    logic [ENT_W-1:0]         parent;
    logic signed [DATA_W-1:0] pos [3];
    logic [ANG_W-1:0]         ang [3];
    logic signed [DATA_W-1:0] scl [3];
  } xform_t;

  // One row of a world matrix
  typedef struct {
    logic [ENT_W-1:0]         entity;
    logic [1:0]               row;
    logic signed [DATA_W-1:0] col [4];
    logic                     is_last;
  } mrow_t;

  // Scoreboard: keeps its own copy of the world matrices and checks rows in order
  class world_scoreboard;
    int   world_mat [ENTITY_COUNT][16];
    bit   world_ok [ENTITY_COUNT];
    mrow_t rows_due [$];
    int   mismatches;

    function new();
      mismatches = 0;
      foreach (world_ok[i]) world_ok[i] = 1'b0;
    endfunction

    function longint fxm(longint a, longint b);
      return (a * b + 64'sd32768) >>> FRAC_BITS;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Binary angle to sine and cosine by quadrant fold and CORDIC
    function void trig(logic [ANG_W-1:0] ang, output longint s, output longint c);
      longint x, y, z, dx, dy, cc, ss;
      int q;
      int atan_steps [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                              5, 3, 1, 1};
      q = ((int'(ang) + 8192) >> 14) & 3;
      z = (longint'(ang) - q * 16384) & 64'hFFFF;
      if (z >= 32768) z -= 65536;
      x = 64'sd652032874;
      y = 0;
      for (int i = 0; i < 15; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_steps[i];
        end else begin
          x += dx; y -= dy; z += atan_steps[i];
        end
      end
      cc = (x + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      ss = (y + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      case (q)
        0: begin c = cc;  s = ss;  end
        1: begin c = -ss; s = cc;  end
        2: begin c = -cc; s = -ss; end
        default: begin c = ss; s = -cc; end
      endcase
    endfunction

    function void mul3(longint a [3][3], longint b [3][3], output longint r [3][3]);
      longint acc;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += fxm(a[i][k], b[k][j]);
          r[i][j] = clamp32(acc);
        end
    endfunction

    // Note an accepted transfer: compose, store and queue its four rows
    function void note_input(xform_t t);
      longint sn [3], cs [3];
      longint rx [3][3], ry [3][3], rz [3][3], rxy [3][3], rr [3][3];
      longint loc [4][4], wld [4][4];
      longint acc;
      bit use_par;
      mrow_t m;
      for (int a = 0; a < 3; a++) trig(t.ang[a], sn[a], cs[a]);
      foreach (rx[i, j]) begin
        rx[i][j] = 0; ry[i][j] = 0; rz[i][j] = 0;
      end
      rx[0][0] = 1 << FRAC_BITS; rx[1][1] = cs[0]; rx[1][2] = -sn[0];
      rx[2][1] = sn[0]; rx[2][2] = cs[0];
      ry[1][1] = 1 << FRAC_BITS; ry[0][0] = cs[1]; ry[0][2] = sn[1];
      ry[2][0] = -sn[1]; ry[2][2] = cs[1];
      rz[2][2] = 1 << FRAC_BITS; rz[0][0] = cs[2]; rz[0][1] = -sn[2];
      rz[1][0] = sn[2]; rz[1][1] = cs[2];
      mul3(rx, ry, rxy);
      mul3(rxy, rz, rr);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) loc[i][j] = clamp32(fxm(rr[i][j], t.scl[j]));
        loc[i][3] = t.pos[i];
        loc[3][i] = 0;
      end
      loc[3][3] = 1 << FRAC_BITS;
      use_par = t.has_parent && world_ok[t.parent];
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++) begin
          if (use_par) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
              acc += fxm(world_mat[t.parent][i * 4 + k], loc[k][j]);
            wld[i][j] = clamp32(acc);
          end else begin
            wld[i][j] = loc[i][j];
          end
        end
      // Store after the parent read so that a self-parent sees its old matrix
      for (int i = 0; i < 16; i++) world_mat[t.entity][i] = int'(wld[i / 4][i % 4]);
      world_ok[t.entity] = 1'b1;
      for (int i = 0; i < 4; i++) begin
        m.entity = t.entity;
        m.row = 2'(i);
        for (int j = 0; j < 4; j++) m.col[j] = DATA_W'(wld[i][j]);
        m.is_last = (i == 3);
        rows_due.push_back(m);
      end
    endfunction

    function void check_row(mrow_t got);
      mrow_t want;
      bit bad;
      if (rows_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected row: entity %0d row %0d", $realtime, got.entity, got.row);
        return;
      end
      want = rows_due.pop_front();
      bad = (got.entity !== want.entity) || (got.row !== want.row) ||
            (got.is_last !== want.is_last);
      for (int j = 0; j < 4; j++) bad |= (got.col[j] !== want.col[j]);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: row mismatch, expected ent %0d row %0d last %0b cols %h %h %h %h",
                   $realtime, want.entity, want.row, want.is_last,
                   want.col[0], want.col[1], want.col[2], want.col[3]);
          $display("%0t:                 actual ent %0d row %0d last %0b cols %h %h %h %h",
                   $realtime, got.entity, got.row, got.is_last,
                   got.col[0], got.col[1], got.col[2], got.col[3]);
        end
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [ENT_W-1:0]         entity_i;
  logic                     has_parent_i;
  logic [ENT_W-1:0]         parent_i;
  logic signed [DATA_W-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic [ANG_W-1:0]         angle_x_i, angle_y_i, angle_z_i;
  logic signed [DATA_W-1:0] scale_x_i, scale_y_i, scale_z_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [ENT_W-1:0]         out_entity_o;
  logic [1:0]               row_index_o;
  logic signed [DATA_W-1:0] col0_o, col1_o, col2_o, col3_o;
  logic                     last_row_o;

  world_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  bit              hold_req;
  int unsigned     hold_left;
  int unsigned     cycle_cnt;

  hierarchical_transform_compose_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .entity_i     (entity_i),
    .has_parent_i (has_parent_i),
    .parent_i     (parent_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .angle_x_i    (angle_x_i),
    .angle_y_i    (angle_y_i),
    .angle_z_i    (angle_z_i),
    .scale_x_i    (scale_x_i),
    .scale_y_i    (scale_y_i),
    .scale_z_i    (scale_z_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_entity_o (out_entity_o),
    .row_index_o  (row_index_o),
    .col0_o       (col0_o),
    .col1_o       (col1_o),
    .col2_o       (col2_o),
    .col3_o       (col3_o),
    .last_row_o   (last_row_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Run watchdog: give up well beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when asked, counted down here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req && hold_left == 0) begin
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      hold_left   <= 0;
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every row transfer against the oldest pending expectation
  always @(posedge clk_i) begin
    mrow_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.entity  = out_entity_o;
      got.row     = row_index_o;
      got.col[0]  = col0_o;
      got.col[1]  = col1_o;
      got.col[2]  = col2_o;
      got.col[3]  = col3_o;
      got.is_last = last_row_o;
      sb.check_row(got);
    end
  end

  function automatic xform_t make_xform(int ent, bit hp, int par, int px, int py, int pz,
      int ax, int ay, int az, int sx, int sy, int sz);
    xform_t t;
    t.entity = ENT_W'(ent); t.has_parent = hp; t.parent = ENT_W'(par);
    t.pos[0] = px; t.pos[1] = py; t.pos[2] = pz;
    t.ang[0] = ANG_W'(ax); t.ang[1] = ANG_W'(ay); t.ang[2] = ANG_W'(az);
    t.scl[0] = sx; t.scl[1] = sy; t.scl[2] = sz;
    return t;
  endfunction

  // Mostly modest coordinates so that chains stay meaningful, sometimes any pattern
  function automatic int pick_pos();
    if ($urandom_range(3) == 0) return int'($urandom());
    return $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
  endfunction

  function automatic int pick_scale();
    int v;
    if ($urandom_range(4) == 0) return int'($urandom());
    v = $urandom_range(32'h0002_0000, 32'h0000_4000);
    return $urandom_range(1) ? -v : v;
  endfunction

  // Random request: mostly parented on a matrix already composed
  function automatic xform_t random_xform();
    int ent, par, pick;
    bit hp;
    ent  = $urandom_range(5) == 0 ? $urandom_range(1023) : $urandom_range(47);
    pick = $urandom_range(9);
    hp   = pick != 0;
    par  = $urandom_range(1023);
    if (pick >= 3) begin
      // hunt for a written parent among the busy entities
      for (int tries = 0; tries < 8; tries++) begin
        par = $urandom_range(47);
        if (sb.world_ok[par]) break;
      end
    end else if (pick == 2) begin
      par = ent;
    end
    return make_xform(ent, hp, par, pick_pos(), pick_pos(), pick_pos(),
                      $urandom_range(16'hFFFF), $urandom_range(16'hFFFF),
                      $urandom_range(16'hFFFF), pick_scale(), pick_scale(), pick_scale());
  endfunction

  // Offer one request; enter and leave at a falling edge
  task automatic send_xform(xform_t t);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i   <= 1'b1;
    entity_i     <= t.entity;
    has_parent_i <= t.has_parent;
    parent_i     <= t.parent;
    pos_x_i      <= t.pos[0];
    pos_y_i      <= t.pos[1];
    pos_z_i      <= t.pos[2];
    angle_x_i    <= t.ang[0];
    angle_y_i    <= t.ang[1];
    angle_z_i    <= t.ang[2];
    scale_x_i    <= t.scl[0];
    scale_y_i    <= t.scl[1];
    scale_z_i    <= t.scl[2];
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(t);
    @(negedge clk_i);
  endtask

  initial begin
    int one, mx, mn;
    int unsigned waited;
    int angle_marks [8] = '{0, 8191, 8192, 16383, 16384, 32767, 32768, 65535};
    sb = new();
    one = 1 << FRAC_BITS;
    mx  = 32'sh7FFF_FFFF;
    mn  = 32'sh8000_0000;
    cycle_cnt = 0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 1'b0;
    hold_left = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    out_ready_i  = 1'b0;
    entity_i     = '0;
    has_parent_i = 1'b0;
    parent_i     = '0;
    pos_x_i      = '0;
    pos_y_i      = '0;
    pos_z_i      = '0;
    angle_x_i    = '0;
    angle_y_i    = '0;
    angle_z_i    = '0;
    scale_x_i    = '0;
    scale_y_i    = '0;
    scale_z_i    = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: plain root, unwritten parent, extremes, chains, self-parent, saturation
    send_xform(make_xform(0, 0, 0, 0, 0, 0, 0, 0, 0, one, one, one));
    send_xform(make_xform(1023, 1, 5, mx, mn, mx, 65535, 65535, 65535, mn, mx, mn));
    send_xform(make_xform(1, 1, 0, one, -one, 3 * one, 8191, 8192, 16384, one, 2 * one,
                          one / 2));
    send_xform(make_xform(2, 1, 1, mn, 0, mx, 24575, 32768, 49152, -one, one, one));
    send_xform(make_xform(2, 1, 2, 5 * one, 7, -9, 1000, 2000, 3000, one, one, one));
    send_xform(make_xform(3, 1, 1023, mx, mx, mx, 40000, 10, 60000, mx, mx, mx));
    send_xform(make_xform(4, 1, 4, -1, -1, -1, 40960, 57344, 1, -one, -one, -one));
    send_xform(make_xform(5, 1, 3, 0, 0, 0, 0, 0, 0, mn, mn, mn));
    send_xform(make_xform(6, 0, 1023, -1, mn, 1, 65535, 0, 65535, -1, 1, mx));
    foreach (angle_marks[k])
      send_xform(make_xform(10 + k, 1, 1, k * one, -k * one, one, angle_marks[k],
                            angle_marks[7 - k], angle_marks[(k + 3) % 8], one, one, one));

    // Random traffic over four idling regimes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < 78; n++) begin
        // hold the output off for a long stretch to back the block up
        if (ph == 0 && n == 20) hold_req = 1'b1;
        if (ph == 0 && n == 22) hold_req = 1'b0;
        send_xform(random_xform());
      end
    end
    in_valid_i <= 1'b0;

    while (sb.rows_due.size() != 0) @(posedge clk_i);
    waited = 0;
    while (waited < TAIL_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/htc_pkg.sv
design/htc_ram.sv
design/htc_ctrl.sv
design/htc_dp.sv
design/hierarchical_transform_compose_top.sv
bench/testbench.sv
